FILE: rtl/core/pps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the priority process scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int NUM_PROCS_DEF = 8;
  localparam int NUM_PRIOS_DEF = 5;

  typedef enum logic [2:0] {
    OP_ADMIT         = 3'd0,
    OP_RELEASE       = 3'd1,
    OP_SET_PRIO      = 3'd2,
    OP_GET_PRIO      = 3'd3,
    OP_MSG_UNBLOCK   = 3'd4,
    OP_PREEMPT_QUERY = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_ARG = 2'd1,
    STAT_NO_PROC = 2'd2
  } status_t;

  localparam logic [1:0] REQ_YIELD = 2'd0;
  localparam logic [1:0] REQ_MEM   = 2'd1;
  localparam logic [1:0] REQ_MSG   = 2'd2;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_READY   = 3'd1,
    ST_RUNNING = 3'd2,
    ST_MEMBLK  = 3'd3,
    ST_MSGBLK  = 3'd4
  } proc_state_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_STATUS,
    CMD_ADMIT,
    CMD_GET_PRIO,
    CMD_PQ_STEP,
    CMD_NEXT_LEVEL,
    CMD_WRITE_PRIO,
    CMD_REM_INIT,
    CMD_REM_STEP,
    CMD_SET_READY,
    CMD_PUSH_PID,
    CMD_REL_INIT,
    CMD_REL_WAKE,
    CMD_REL_POP,
    CMD_REL_PUSH,
    CMD_REL_END,
    CMD_PUBLISH
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t cmd;
    status_t code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic admit_bad;
    logic req_bad;
    logic setp_bad;
    logic same_prio;
    logic pid_admitted;
    logic pid_is_cur;
    logic setp_preempt;
    logic getp_bad;
    logic unblk_bad;
    logic cur_none;
    logic pq_hit;
    logic pq_last;
    logic scan_last;
    logic ready_ne;
    logic rel_last;
    logic rem_done;
    logic out_busy;
  } dp_flags_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_ADMIT,
    S_GET_PRIO,
    S_PQ,
    S_SP_ONLY,
    S_SP_CUR,
    S_SCAN,
    S_SR_INIT,
    S_SR_WALK,
    S_SR_WRITE,
    S_SR_PUSH,
    S_SR_CHECK,
    S_UB_INIT,
    S_UB_WALK,
    S_UB_READY,
    S_UB_PUSH,
    S_REL_INIT,
    S_REL_WAKE,
    S_REL_CHECK,
    S_REL_POP,
    S_REL_PUSH,
    S_REL_END,
    S_FIN
  } ctrl_state_t;

endpackage

FILE: rtl/core/pps_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_dp
// Scheduler datapath: process tables, linked queues, walk and scan registers.
// ----------------------------------------------------------------------------
module pps_dp #(
  parameter int NUM_PROCS = pps_pkg::NUM_PROCS_DEF,
  parameter int NUM_PRIOS = pps_pkg::NUM_PRIOS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  pps_pkg::ctrl_cmd_t ctl,
  output pps_pkg::dp_flags_t flags,
  input  logic [2:0]         operation,
  input  logic [2:0]         target_pid,
  input  logic [2:0]         target_prio,
  input  logic [1:0]         current_request,
  input  logic               memory_available,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         status,
  output logic [2:0]         running_pid,
  output logic               switched,
  output logic               first_run,
  output logic [2:0]         priority_out,
  output logic               preempt_needed
);
  import pps_pkg::*;

  localparam int PIDX_W = $clog2(NUM_PROCS);
  localparam int PW     = $clog2(NUM_PROCS + 1);
  localparam int PRW    = $clog2(NUM_PRIOS);
  localparam int LW     = $clog2(NUM_PRIOS + 1);
  localparam int NQ     = 3 * NUM_PRIOS;
  localparam int QW     = $clog2(NQ);
  localparam int CW     = $clog2(NUM_PROCS + 1);
  localparam logic [PW-1:0] NONE = PW'(NUM_PROCS);

  proc_state_t       proc_state    [NUM_PROCS];
  logic [PRW-1:0]    proc_priority [NUM_PROCS];
  logic              proc_admitted [NUM_PROCS];
  logic [PIDX_W-1:0] next_link     [NUM_PROCS];
  logic [PW-1:0]     queue_head    [NQ];
  logic [PIDX_W-1:0] queue_tail    [NQ];
  logic [PW-1:0]     running;

  // latched transaction
  logic [2:0] op_r, pid_r, np_r;
  logic [1:0] req_r;
  logic       mem_r;
  logic [PW-1:0] cur_r;

  logic [PRW-1:0] lvl;
  logic [LW-1:0]  lim;
  logic [QW-1:0]  rq;
  logic [PW-1:0]  wcur, wprev;
  logic [CW-1:0]  wn;

  status_t    res_status;
  logic       res_sw, res_first, res_pre;
  logic [2:0] res_prio;

  function automatic logic [QW-1:0] queue_of(proc_state_t st, logic [PRW-1:0] pr);
    logic [QW-1:0] base;
    base = '0;
    if (st == ST_MEMBLK) base = QW'(NUM_PRIOS);
    else if (st == ST_MSGBLK) base = QW'(2 * NUM_PRIOS);
    return base + QW'(pr);
  endfunction

  logic [PIDX_W-1:0] pidx, cidx;
  logic [PW-1:0]     pidw;
  logic [PRW-1:0]    npv;
  logic              pid_ok, np_ok, np_set_ok, cur_none;
  logic [QW-1:0]     qr, qm, qp, qc;
  logic [PW-1:0]     hr, hm;
  logic [1:0]        eff_req;

  assign pidx      = PIDX_W'(pid_r);
  assign pidw      = PW'(pid_r);
  assign npv       = PRW'(np_r);
  assign cidx      = cur_r[PIDX_W-1:0];
  assign pid_ok    = int'(pid_r) < NUM_PROCS;
  assign np_ok     = int'(np_r) < NUM_PRIOS;
  assign np_set_ok = int'(np_r) < NUM_PRIOS - 1;
  assign cur_none  = (cur_r == NONE);
  assign qr        = QW'(lvl);
  assign qm        = QW'(NUM_PRIOS) + QW'(lvl);
  assign hr        = queue_head[qr];
  assign hm        = queue_head[qm];
  assign qp        = queue_of(proc_state[pidx], proc_priority[pidx]);
  assign qc        = queue_of(proc_state[cidx], proc_priority[cidx]);
  // a priority change runs the release path as a plain yield
  assign eff_req   = (op_r == OP_RELEASE) ? req_r : REQ_YIELD;

  always_comb begin
    flags.op           = op_r;
    flags.admit_bad    = !pid_ok || !np_ok || proc_admitted[pidx];
    flags.req_bad      = req_r > REQ_MSG;
    flags.setp_bad     = (pid_r == 3'd0) || !pid_ok || !np_set_ok;
    flags.same_prio    = proc_priority[pidx] == npv;
    flags.pid_admitted = proc_admitted[pidx];
    flags.pid_is_cur   = pidw == cur_r;
    flags.setp_preempt = (proc_state[pidx] != ST_MEMBLK) && (proc_state[pidx] != ST_MSGBLK)
                         && !cur_none && (npv <= proc_priority[cidx]);
    flags.getp_bad     = !pid_ok;
    flags.unblk_bad    = !pid_ok || !proc_admitted[pidx] || (proc_state[pidx] != ST_MSGBLK);
    flags.cur_none     = cur_none;
    flags.pq_hit       = hm != NONE;
    flags.pq_last      = lvl == proc_priority[cidx];
    flags.scan_last    = lvl == npv;
    flags.ready_ne     = hr != NONE;
    flags.rel_last     = (LW'(lvl) + LW'(1)) >= lim;
    flags.rem_done     = (wcur == NONE) || (int'(wn) == NUM_PROCS) || (wcur == pidw)
                         || (wcur[PIDX_W-1:0] == queue_tail[rq]);
    flags.out_busy     = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_PROCS; k++) begin
        proc_state[k]    <= ST_NEW;
        proc_priority[k] <= '0;
        proc_admitted[k] <= 1'b0;
      end
      for (int k = 0; k < NQ; k++) queue_head[k] <= NONE;
      running   <= NONE;
      out_valid <= 1'b0;
    end else begin
      if (ctl.cmd == CMD_PUBLISH) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      case (ctl.cmd)
        CMD_LOAD: begin
          op_r       <= operation;
          pid_r      <= target_pid;
          np_r       <= target_prio;
          req_r      <= current_request;
          mem_r      <= memory_available;
          cur_r      <= running;
          lvl        <= '0;
          res_status <= STAT_OK;
          res_sw     <= 1'b0;
          res_first  <= 1'b0;
          res_prio   <= '0;
          res_pre    <= 1'b0;
        end
        CMD_STATUS: res_status <= ctl.code;
        CMD_ADMIT: begin
          proc_admitted[pidx] <= 1'b1;
          proc_priority[pidx] <= npv;
          proc_state[pidx]    <= ST_NEW;
          if (queue_head[QW'(npv)] == NONE) queue_head[QW'(npv)] <= pidw;
          else next_link[queue_tail[QW'(npv)]] <= pidx;
          queue_tail[QW'(npv)] <= pidx;
        end
        CMD_GET_PRIO: res_prio <= 3'(proc_priority[pidx]);
        CMD_PQ_STEP: begin
          if (hm != NONE) res_pre <= 1'b1;
          lvl <= lvl + PRW'(1);
        end
        CMD_NEXT_LEVEL: lvl <= lvl + PRW'(1);
        CMD_WRITE_PRIO: proc_priority[pidx] <= npv;
        CMD_REM_INIT: begin
          rq    <= qp;
          wcur  <= queue_head[qp];
          wprev <= NONE;
          wn    <= '0;
        end
        CMD_REM_STEP: begin
          if ((wcur != NONE) && (int'(wn) != NUM_PROCS)) begin
            if (wcur == pidw) begin
              if (wprev == NONE) begin
                queue_head[rq] <= (wcur[PIDX_W-1:0] == queue_tail[rq]) ? NONE
                                  : PW'(next_link[wcur[PIDX_W-1:0]]);
              end else begin
                next_link[wprev[PIDX_W-1:0]] <= next_link[wcur[PIDX_W-1:0]];
                if (wcur[PIDX_W-1:0] == queue_tail[rq])
                  queue_tail[rq] <= wprev[PIDX_W-1:0];
              end
            end else if (wcur[PIDX_W-1:0] != queue_tail[rq]) begin
              wprev <= wcur;
              wcur  <= PW'(next_link[wcur[PIDX_W-1:0]]);
              wn    <= wn + CW'(1);
            end
          end
        end
        CMD_SET_READY: proc_state[pidx] <= ST_READY;
        CMD_PUSH_PID: begin
          if (queue_head[qp] == NONE) queue_head[qp] <= pidw;
          else next_link[queue_tail[qp]] <= pidx;
          queue_tail[qp] <= pidx;
        end
        CMD_REL_INIT: begin
          if (!cur_none) begin
            if (eff_req == REQ_MEM) proc_state[cidx] <= ST_MEMBLK;
            else if (eff_req == REQ_MSG) proc_state[cidx] <= ST_MSGBLK;
            else proc_state[cidx] <= ST_READY;
          end
          if (!cur_none && (eff_req == REQ_YIELD)) lim <= LW'(proc_priority[cidx]) + LW'(1);
          else lim <= LW'(NUM_PRIOS);
          lvl <= '0;
        end
        CMD_REL_WAKE: begin
          // move the memory-blocked head at this level to the ready queue when memory is available
          if (mem_r && (hm != NONE)) begin
            queue_head[qm] <= (hm[PIDX_W-1:0] == queue_tail[qm]) ? NONE
                              : PW'(next_link[hm[PIDX_W-1:0]]);
            proc_state[hm[PIDX_W-1:0]] <= ST_READY;
            if (hr == NONE) queue_head[qr] <= hm;
            else next_link[queue_tail[qr]] <= hm[PIDX_W-1:0];
            queue_tail[qr] <= hm[PIDX_W-1:0];
          end
        end
        CMD_REL_POP: begin
          queue_head[qr] <= (hr[PIDX_W-1:0] == queue_tail[qr]) ? NONE
                            : PW'(next_link[hr[PIDX_W-1:0]]);
          res_first <= proc_state[hr[PIDX_W-1:0]] == ST_NEW;
          proc_state[hr[PIDX_W-1:0]] <= ST_RUNNING;
          running <= hr;
          res_sw  <= 1'b1;
        end
        CMD_REL_PUSH: begin
          if (!cur_none) begin
            if (queue_head[qc] == NONE) queue_head[qc] <= cur_r;
            else next_link[queue_tail[qc]] <= cidx;
            queue_tail[qc] <= cidx;
          end
        end
        CMD_REL_END: begin
          if (!cur_none) proc_state[cidx] <= ST_RUNNING;
          if (op_r == OP_RELEASE)
            res_status <= (cur_none || (req_r != REQ_YIELD)) ? STAT_NO_PROC : STAT_OK;
        end
        CMD_PUBLISH: begin
          status         <= res_status;
          running_pid    <= (running == NONE) ? 3'd0 : 3'(running);
          switched       <= res_sw;
          first_run      <= res_first;
          priority_out   <= res_prio;
          preempt_needed <= res_pre;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/pps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_ctrl
// Scheduler sequencer: decodes the operation and steps the datapath.
// ----------------------------------------------------------------------------
module pps_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pps_pkg::dp_flags_t flags,
  output pps_pkg::ctrl_cmd_t ctl
);
  import pps_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        case (flags.op)
          OP_ADMIT:       state_next = flags.admit_bad ? S_FIN : S_ADMIT;
          OP_RELEASE:     state_next = flags.req_bad ? S_FIN : S_REL_INIT;
          OP_SET_PRIO: begin
            if (flags.setp_bad || flags.same_prio) state_next = S_FIN;
            else if (!flags.pid_admitted) state_next = S_SP_ONLY;
            else if (flags.pid_is_cur) state_next = S_SP_CUR;
            else state_next = S_SR_INIT;
          end
          OP_GET_PRIO:      state_next = flags.getp_bad ? S_FIN : S_GET_PRIO;
          OP_MSG_UNBLOCK:   state_next = flags.unblk_bad ? S_FIN : S_UB_INIT;
          OP_PREEMPT_QUERY: state_next = flags.cur_none ? S_FIN : S_PQ;
          default:          state_next = S_FIN;
        endcase
      end
      S_ADMIT, S_GET_PRIO, S_SP_ONLY: state_next = S_FIN;
      S_PQ: if (flags.pq_hit || flags.pq_last) state_next = S_FIN;
      S_SP_CUR: state_next = S_SCAN;
      S_SCAN: begin
        if (flags.ready_ne) state_next = S_REL_INIT;
        else if (flags.scan_last) state_next = S_FIN;
      end
      S_SR_INIT:  state_next = S_SR_WALK;
      S_SR_WALK:  if (flags.rem_done) state_next = S_SR_WRITE;
      S_SR_WRITE: state_next = S_SR_PUSH;
      S_SR_PUSH:  state_next = S_SR_CHECK;
      S_SR_CHECK: state_next = flags.setp_preempt ? S_REL_INIT : S_FIN;
      S_UB_INIT:  state_next = S_UB_WALK;
      S_UB_WALK:  if (flags.rem_done) state_next = S_UB_READY;
      S_UB_READY: state_next = S_UB_PUSH;
      S_UB_PUSH:  state_next = S_FIN;
      S_REL_INIT: state_next = S_REL_WAKE;
      S_REL_WAKE: state_next = S_REL_CHECK;
      S_REL_CHECK: begin
        if (flags.ready_ne) state_next = S_REL_POP;
        else if (flags.rel_last) state_next = S_REL_END;
        else state_next = S_REL_WAKE;
      end
      S_REL_POP:  state_next = S_REL_PUSH;
      S_REL_PUSH, S_REL_END: state_next = S_FIN;
      S_FIN: if (!flags.out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.cmd  = CMD_NONE;
    ctl.code = STAT_OK;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) ctl.cmd = CMD_LOAD;
      end
      S_DECODE: begin
        case (flags.op)
          OP_ADMIT:         if (flags.admit_bad) ctl.cmd = CMD_STATUS;
          OP_RELEASE:       if (flags.req_bad) ctl.cmd = CMD_STATUS;
          OP_SET_PRIO:      if (flags.setp_bad) ctl.cmd = CMD_STATUS;
          OP_GET_PRIO:      if (flags.getp_bad) ctl.cmd = CMD_STATUS;
          OP_MSG_UNBLOCK:   if (flags.unblk_bad) ctl.cmd = CMD_STATUS;
          OP_PREEMPT_QUERY: if (flags.cur_none) ctl.cmd = CMD_STATUS;
          default:          ctl.cmd = CMD_STATUS;
        endcase
        ctl.code = (flags.op == OP_PREEMPT_QUERY) ? STAT_NO_PROC : STAT_BAD_ARG;
      end
      S_ADMIT:    ctl.cmd = CMD_ADMIT;
      S_GET_PRIO: ctl.cmd = CMD_GET_PRIO;
      S_PQ:       ctl.cmd = CMD_PQ_STEP;
      S_SP_ONLY, S_SP_CUR, S_SR_WRITE: ctl.cmd = CMD_WRITE_PRIO;
      S_SCAN:     if (!flags.ready_ne && !flags.scan_last) ctl.cmd = CMD_NEXT_LEVEL;
      S_SR_INIT, S_UB_INIT: ctl.cmd = CMD_REM_INIT;
      S_SR_WALK, S_UB_WALK: ctl.cmd = CMD_REM_STEP;
      S_SR_PUSH, S_UB_PUSH: ctl.cmd = CMD_PUSH_PID;
      S_UB_READY: ctl.cmd = CMD_SET_READY;
      S_REL_INIT: ctl.cmd = CMD_REL_INIT;
      S_REL_WAKE: ctl.cmd = CMD_REL_WAKE;
      S_REL_CHECK: if (!flags.ready_ne && !flags.rel_last) ctl.cmd = CMD_NEXT_LEVEL;
      S_REL_POP:  ctl.cmd = CMD_REL_POP;
      S_REL_PUSH: ctl.cmd = CMD_REL_PUSH;
      S_REL_END:  ctl.cmd = CMD_REL_END;
      S_FIN:      if (!flags.out_busy) ctl.cmd = CMD_PUBLISH;
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/priority_process_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_process_scheduler
// Multilevel priority scheduler with per-level linked ready/blocked queues.
//
//   channel  handshake            payload
//   in       in_valid / in_ready  operation, target_pid, target_prio,
//                                 current_request, memory_available
//   out      out_valid/out_ready  status, running_pid, switched, first_run,
//                                 priority_out, preempt_needed
//
// One transaction at a time: release visits each priority level in a wake
// state and a check state, list removal one node a cycle.
// in_ready is high only in idle; the next transaction may enter while the
// last result waits in the output register.
// Synchronous active-high reset empties all queues, marks all processes new.
// ----------------------------------------------------------------------------
module priority_process_scheduler #(
  parameter int NUM_PROCS = pps_pkg::NUM_PROCS_DEF,
  parameter int NUM_PRIOS = pps_pkg::NUM_PRIOS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] operation,
  input  logic [2:0] target_pid,
  input  logic [2:0] target_prio,
  input  logic [1:0] current_request,
  input  logic       memory_available,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [2:0] running_pid,
  output logic       switched,
  output logic       first_run,
  output logic [2:0] priority_out,
  output logic       preempt_needed
);
  import pps_pkg::*;

  ctrl_cmd_t ctl;
  dp_flags_t flags;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .flags    (flags),
    .ctl      (ctl)
  );

  pps_dp #(
    .NUM_PROCS (NUM_PROCS),
    .NUM_PRIOS (NUM_PRIOS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .flags            (flags),
    .operation        (operation),
    .target_pid       (target_pid),
    .target_prio      (target_prio),
    .current_request  (current_request),
    .memory_available (memory_available),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .status           (status),
    .running_pid      (running_pid),
    .switched         (switched),
    .first_run        (first_run),
    .priority_out     (priority_out),
    .preempt_needed   (preempt_needed)
  );

endmodule

FILE: tb/priority_process_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_process_scheduler_tb
// Drives scheduler operations through the valid/ready input channel and checks
// every result against a behavioral scheduler kept in the testbench. A short
// table of directed transactions comes first, then random operation mixes.
// ----------------------------------------------------------------------------
module priority_process_scheduler_tb;
  import pps_pkg::*;

  localparam int NP = 8;
  localparam int NL = 5;
  localparam int NQ = 3 * NL;
  localparam int NONE = NP;
  localparam int N_RANDOM = 1150;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] pid;
    logic [2:0] prio;
    logic [1:0] req;
    logic       mem;
  } sched_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] run;
    logic       sw;
    logic       first;
    logic [2:0] prio;
    logic       preempt;
  } sched_res_t;

  typedef struct packed {
    sched_req_t rq;
    logic       has_res;
    sched_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] operation = '0;
  logic [2:0] target_pid = '0;
  logic [2:0] target_prio = '0;
  logic [1:0] current_request = '0;
  logic memory_available = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [2:0] running_pid;
  logic switched;
  logic first_run;
  logic [2:0] priority_out;
  logic preempt_needed;

  priority_process_scheduler uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .target_pid(target_pid), .target_prio(target_prio),
    .current_request(current_request), .memory_available(memory_available),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .running_pid(running_pid), .switched(switched),
    .first_run(first_run), .priority_out(priority_out),
    .preempt_needed(preempt_needed)
  );

  // scheduler shadow state
  int prio_of[NP];
  proc_state_t pstate[NP];
  bit admitted[NP];
  int link[NP];
  int qhead[NQ];
  int qtail[NQ];
  int running;
  int sw_flag, first_flag;

  sched_res_t expected_q[$];
  int errors = 0;
  bit stim_done = 1'b0;
  dir_row_t dir_rows[$];

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic void sched_reset();
    for (int i = 0; i < NP; i++) begin
      prio_of[i] = 0;
      pstate[i] = ST_NEW;
      admitted[i] = 0;
      link[i] = 0;
    end
    for (int i = 0; i < NQ; i++) begin
      qhead[i] = NONE;
      qtail[i] = 0;
    end
    running = NONE;
  endfunction

  function automatic void q_append(int q, int p);
    if (qhead[q] >= NONE) qhead[q] = p;
    else link[qtail[q]] = p;
    qtail[q] = p;
  endfunction

  function automatic int q_take(int q);
    int p;
    p = qhead[q];
    if (p >= NONE) return NONE;
    qhead[q] = (p == qtail[q]) ? NONE : link[p];
    return p;
  endfunction

  function automatic void q_unlink(int q, int p);
    int prev, c;
    prev = NONE;
    c = qhead[q];
    for (int n = 0; n < NONE && c < NONE; n++) begin
      if (c == p) begin
        if (prev >= NONE) qhead[q] = (c == qtail[q]) ? NONE : link[c];
        else begin
          link[prev] = link[c];
          if (c == qtail[q]) qtail[q] = prev;
        end
        return;
      end
      if (c == qtail[q]) return;
      prev = c;
      c = link[c];
    end
  endfunction

  function automatic int queue_index(int p);
    int kind;
    kind = (pstate[p] == ST_MEMBLK) ? 1 : (pstate[p] == ST_MSGBLK) ? 2 : 0;
    return kind * NL + prio_of[p];
  endfunction

  function automatic int dispatch(int req, bit mem);
    int c, lim, p;
    c = running;
    lim = NL;
    if (c < NONE) begin
      pstate[c] = (req == REQ_MEM) ? ST_MEMBLK : (req == REQ_MSG) ? ST_MSGBLK : ST_READY;
      if (req == REQ_YIELD) lim = prio_of[c] + 1;
    end
    for (int i = 0; i < lim && i < NL; i++) begin
      // wake memory-blocked head at this level first
      if (mem && qhead[NL + i] < NONE) begin
        p = q_take(NL + i);
        pstate[p] = ST_READY;
        q_append(i, p);
      end
      if (qhead[i] < NONE) begin
        p = q_take(i);
        if (c < NONE) q_append(queue_index(c), c);
        first_flag = (pstate[p] == ST_NEW);
        pstate[p] = ST_RUNNING;
        running = p;
        sw_flag = 1;
        return STAT_OK;
      end
    end
    if (c < NONE) pstate[c] = ST_RUNNING;
    return (c >= NONE || req != REQ_YIELD) ? STAT_NO_PROC : STAT_OK;
  endfunction

  function automatic sched_res_t sched_step(sched_req_t rq);
    sched_res_t r;
    int st, po, pre, c, old;
    st = STAT_OK; po = 0; pre = 0;
    sw_flag = 0; first_flag = 0;
    c = running;
    case (rq.op)
      OP_ADMIT: begin
        if (rq.prio >= NL || admitted[rq.pid]) st = STAT_BAD_ARG;
        else begin
          admitted[rq.pid] = 1;
          prio_of[rq.pid] = rq.prio;
          pstate[rq.pid] = ST_NEW;
          q_append(rq.prio, rq.pid);
        end
      end
      OP_RELEASE: begin
        if (rq.req > REQ_MSG) st = STAT_BAD_ARG;
        else st = dispatch(rq.req, rq.mem);
      end
      OP_SET_PRIO: begin
        old = prio_of[rq.pid];
        if (rq.pid == 0 || rq.prio >= NL - 1) st = STAT_BAD_ARG;
        else if (old == rq.prio) begin
        end else if (!admitted[rq.pid]) prio_of[rq.pid] = rq.prio;
        else if (rq.pid == c) begin
          prio_of[rq.pid] = rq.prio;
          for (int i = 0; i <= rq.prio; i++)
            if (qhead[i] < NONE) begin
              void'(dispatch(REQ_YIELD, rq.mem));
              break;
            end
        end else begin
          q_unlink(queue_index(rq.pid), rq.pid);
          prio_of[rq.pid] = rq.prio;
          q_append(queue_index(rq.pid), rq.pid);
          if (queue_index(rq.pid) < NL && c < NONE && rq.prio <= prio_of[c])
            void'(dispatch(REQ_YIELD, rq.mem));
        end
      end
      OP_GET_PRIO: po = prio_of[rq.pid];
      OP_MSG_UNBLOCK: begin
        if (!admitted[rq.pid] || pstate[rq.pid] != ST_MSGBLK) st = STAT_BAD_ARG;
        else begin
          q_unlink(queue_index(rq.pid), rq.pid);
          pstate[rq.pid] = ST_READY;
          q_append(queue_index(rq.pid), rq.pid);
        end
      end
      OP_PREEMPT_QUERY: begin
        if (c >= NONE) st = STAT_NO_PROC;
        else
          for (int i = 0; i <= prio_of[c] && i < NL; i++)
            if (qhead[NL + i] < NONE) begin
              pre = 1;
              break;
            end
      end
      default: st = STAT_BAD_ARG;
    endcase
    r.status = 2'(st);
    r.run = (running < NONE) ? 3'(running) : 3'd0;
    r.sw = 1'(sw_flag);
    r.first = 1'(first_flag);
    r.prio = 3'(po);
    r.preempt = 1'(pre);
    return r;
  endfunction

  // idle gaps: mostly short, sometimes long, sometimes none
  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(input sched_req_t rq, input bit has_res, input sched_res_t res);
    sched_res_t pred;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= rq.op;
    target_pid <= rq.pid;
    target_prio <= rq.prio;
    current_request <= rq.req;
    memory_available <= rq.mem;
    do @(posedge clk); while (!in_ready);
    pred = sched_step(rq);
    if (has_res && pred != res) begin
      report_mismatch("table row vs predictor", int'(pred), int'(res));
    end
    expected_q.push_back(pred);
  endtask

  function automatic sched_req_t mk(int op, int pid, int prio, int req, int mem);
    sched_req_t r;
    r.op = 3'(op); r.pid = 3'(pid); r.prio = 3'(prio); r.req = 2'(req); r.mem = 1'(mem);
    return r;
  endfunction

  function automatic sched_res_t rs(int st, int run, int sw, int fr, int po, int pre);
    sched_res_t r;
    r.status = 2'(st); r.run = 3'(run); r.sw = 1'(sw); r.first = 1'(fr);
    r.prio = 3'(po); r.preempt = 1'(pre);
    return r;
  endfunction

  function automatic void row(sched_req_t rq, bit has, sched_res_t res);
    dir_row_t d;
    d.rq = rq; d.has_res = has; d.res = res;
    dir_rows.push_back(d);
  endfunction

  // mostly valid operations on random process ids, some noise
  function automatic sched_req_t random_req();
    sched_req_t r;
    int k;
    k = $urandom_range(0, 99);
    r.pid = 3'($urandom_range(0, 7));
    r.prio = ($urandom_range(0, 99) < 90) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
    r.req = ($urandom_range(0, 99) < 92) ? 2'($urandom_range(0, 2)) : 2'd3;
    r.mem = 1'($urandom_range(0, 1));
    if (k < 10) r.op = OP_ADMIT;
    else if (k < 50) r.op = OP_RELEASE;
    else if (k < 65) r.op = OP_SET_PRIO;
    else if (k < 72) r.op = OP_GET_PRIO;
    else if (k < 85) r.op = OP_MSG_UNBLOCK;
    else if (k < 97) r.op = OP_PREEMPT_QUERY;
    else r.op = 3'($urandom_range(6, 7));
    return r;
  endfunction

  // result side
  always @(posedge clk) begin
    sched_res_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) report_mismatch("unexpected result", status, -1);
        else begin
          want = expected_q.pop_front();
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (running_pid !== want.run) report_mismatch("running_pid", running_pid, want.run);
          if (switched !== want.sw) report_mismatch("switched", switched, want.sw);
          if (first_run !== want.first) report_mismatch("first_run", first_run, want.first);
          if (priority_out !== want.prio)
            report_mismatch("priority_out", priority_out, want.prio);
          if (preempt_needed !== want.preempt)
            report_mismatch("preempt_needed", preempt_needed, want.preempt);
        end
      end
    end
  end

  // output stall pattern with calm stretches
  initial begin
    int g;
    @(negedge rst);
    forever begin
      @(posedge clk);
      g = gap_len();
      if (g == 0 || $urandom_range(0, 3) == 0) out_ready <= 1'b1;
      else begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int wait_cnt;
    sched_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; expected results written in only where obvious
    row(mk(OP_RELEASE, 0, 0, REQ_YIELD, 0), 1, rs(STAT_NO_PROC, 0, 0, 0, 0, 0));
    row(mk(OP_PREEMPT_QUERY, 0, 0, 0, 0), 1, rs(STAT_NO_PROC, 0, 0, 0, 0, 0));
    row(mk(OP_GET_PRIO, 7, 0, 0, 0), 1, rs(STAT_OK, 0, 0, 0, 0, 0));
    row(mk(OP_ADMIT, 7, 5, 0, 0), 1, rs(STAT_BAD_ARG, 0, 0, 0, 0, 0));
    row(mk(OP_ADMIT, 7, 4, 0, 0), 1, rs(STAT_OK, 0, 0, 0, 0, 0));
    row(mk(OP_ADMIT, 7, 4, 0, 0), 1, rs(STAT_BAD_ARG, 0, 0, 0, 0, 0));
    row(mk(OP_ADMIT, 0, 0, 0, 0), 1, rs(STAT_OK, 0, 0, 0, 0, 0));
    row(mk(OP_ADMIT, 3, 2, 0, 1), 0, '0);
    row(mk(OP_RELEASE, 0, 0, 3, 1), 1, rs(STAT_BAD_ARG, 0, 0, 0, 0, 0));
    row(mk(OP_RELEASE, 0, 0, REQ_YIELD, 0), 1, rs(STAT_OK, 0, 1, 1, 0, 0));
    row(mk(OP_RELEASE, 0, 0, REQ_YIELD, 0), 0, '0);
    row(mk(OP_RELEASE, 0, 0, REQ_MEM, 0), 0, '0);
    row(mk(OP_PREEMPT_QUERY, 0, 0, 0, 0), 0, '0);
    row(mk(OP_RELEASE, 0, 0, REQ_MSG, 1), 0, '0);
    row(mk(OP_MSG_UNBLOCK, 2, 0, 0, 0), 1, rs(STAT_BAD_ARG, 0, 0, 0, 0, 0));
    row(mk(OP_MSG_UNBLOCK, 3, 0, 0, 0), 0, '0);
    row(mk(OP_SET_PRIO, 0, 1, 0, 0), 0, '0);
    row(mk(OP_SET_PRIO, 7, 4, 0, 0), 0, '0);
    row(mk(OP_SET_PRIO, 7, 0, 0, 1), 0, '0);
    row(mk(OP_SET_PRIO, 5, 3, 0, 0), 0, '0);
    row(mk(OP_GET_PRIO, 5, 0, 0, 0), 0, '0);
    row(mk(OP_SET_PRIO, 7, 3, 0, 0), 0, '0);
    row(mk(6, 0, 0, 0, 0), 0, '0);
    row(mk(7, 7, 7, 3, 1), 0, '0);
    foreach (dir_rows[i]) send(dir_rows[i].rq, dir_rows[i].has_res, dir_rows[i].res);

    for (int n = 0; n < N_RANDOM; n++) send(random_req(), 0, '0);
    in_valid <= 1'b0;

    wait_cnt = 0;
    while (expected_q.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

FILE: files.f
rtl/core/pps_pkg.sv
rtl/core/pps_dp.sv
rtl/core/pps_ctrl.sv
rtl/core/priority_process_scheduler.sv
tb/priority_process_scheduler_tb.sv
